[rtl/lic_pkg.sv]
package lic_pkg;

	localparam int TABLE_DEPTH_DEF = 1024;
	localparam int SUM_BITS_DEF    = 48;

	localparam int SAMPLE_BITS = 12;
	localparam int OUT_W       = 48;
	localparam int ADDR_W      = 10;
	localparam int VALUE_W     = 16;
	localparam int LEN_W       = 11;
	localparam int OFF_W       = 10;
	localparam int BUF_W       = 7;
	localparam int CNT_W       = 8;
	localparam int CFG_IDX_W   = 2;
	localparam int CFG_DATA_W  = 11;

	localparam int MID_DEPTH = 4;
	localparam int OUT_DEPTH = 2;

	localparam logic [LEN_W-1:0] BUFFER_LENGTH_RST   = 11'd1000;
	localparam logic [OFF_W-1:0] COSINE_OFFSET_RST   = 10'd250;
	localparam logic [BUF_W-1:0] SETTLE_BUFFERS_RST  = 7'd2;
	localparam logic [BUF_W-1:0] MEASURE_BUFFERS_RST = 7'd100;

	typedef enum logic [1:0] {
		OP_LOAD   = 2'd0,
		OP_START  = 2'd1,
		OP_SAMPLE = 2'd2
	} opcode_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_BUFFER_LENGTH   = 2'd0,
		REG_COSINE_OFFSET   = 2'd1,
		REG_SETTLE_BUFFERS  = 2'd2,
		REG_MEASURE_BUFFERS = 2'd3
	} cfg_reg_t;

	// effective settings seen by the front end
	typedef struct packed {
		logic [LEN_W-1:0] len;
		logic [OFF_W-1:0] cos_off;
		logic [BUF_W-1:0] settle;
		logic [BUF_W-1:0] meas;
	} cfg_t;

	typedef struct packed {
		logic                   is_load;
		logic                   wr_ok;
		logic [ADDR_W-1:0]      addr;
		logic [VALUE_W-1:0]     value;
		logic [ADDR_W-1:0]      sin_idx;
		logic [LEN_W-1:0]       cos_idx;
		logic [SAMPLE_BITS-1:0] cur;
		logic [SAMPLE_BITS-1:0] vol;
		logic                   clear;
		logic                   acc;
		logic                   emit;
	} op_t;

	typedef struct packed {
		logic [OUT_W-1:0] cur_re;
		logic [OUT_W-1:0] cur_im;
		logic [OUT_W-1:0] vol_re;
		logic [OUT_W-1:0] vol_im;
	} res_t;

endpackage

[rtl/lic_fifo.sv]
module lic_fifo #(
	parameter type T = logic,
	parameter int DEPTH = 4
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  T     wdata,
	input  logic pop,
	output T     rdata,
	output logic full,
	output logic empty
);

	localparam int PW = $clog2(DEPTH);
	localparam int CW = PW + 1;

	T              entries_q [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] cnt_q;
	logic          do_push;
	logic          do_pop;

	assign full    = (cnt_q == CW'(DEPTH));
	assign empty   = (cnt_q == '0);
	assign do_push = push & ~full;
	assign do_pop  = pop & ~empty;
	assign rdata   = entries_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) wr_ptr_q <= wr_ptr_q + PW'(1);
			if (do_pop) rd_ptr_q <= rd_ptr_q + PW'(1);
			if (do_push && !do_pop) cnt_q <= cnt_q + CW'(1);
			else if (do_pop && !do_push) cnt_q <= cnt_q - CW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) entries_q[wr_ptr_q] <= wdata;
	end

endmodule

[rtl/lic_offset_mod.sv]
module lic_offset_mod (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic [lic_pkg::OFF_W-1:0] dividend,
	input  logic [lic_pkg::LEN_W-1:0] divisor,
	output logic                      busy,
	output logic [lic_pkg::OFF_W-1:0] rem
);

	localparam int OFF_W  = lic_pkg::OFF_W;
	localparam int LEN_W  = lic_pkg::LEN_W;
	localparam int STEP_W = $clog2(OFF_W + 1);

	logic              start_q;
	logic [STEP_W-1:0] step_q;
	logic [OFF_W-1:0]  dvd_q;
	logic [LEN_W-1:0]  rem_q;
	logic [LEN_W:0]    shifted;
	logic [LEN_W-1:0]  rem_next;

	// restoring remainder, one dividend bit per cycle
	always_comb begin
		shifted = {rem_q, dvd_q[OFF_W-1]};
		if (shifted >= {1'b0, divisor}) rem_next = LEN_W'(shifted - {1'b0, divisor});
		else rem_next = LEN_W'(shifted);
	end

	assign busy = start_q | (step_q != '0);
	assign rem  = OFF_W'(rem_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_q <= 1'b1;
			step_q  <= '0;
		end else begin
			start_q <= start;
			if (start_q) step_q <= STEP_W'(OFF_W);
			else if (step_q != '0) step_q <= step_q - STEP_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (start_q) begin
			dvd_q <= dividend;
			rem_q <= '0;
		end else if (step_q != '0) begin
			dvd_q <= {dvd_q[OFF_W-2:0], 1'b0};
			rem_q <= rem_next;
		end
	end

endmodule

[rtl/lic_front.sv]
module lic_front #(
	parameter int TABLE_DEPTH = lic_pkg::TABLE_DEPTH_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            push,
	output logic                            full,
	input  logic [1:0]                      opcode,
	input  logic [lic_pkg::ADDR_W-1:0]      table_address,
	input  logic [lic_pkg::VALUE_W-1:0]     table_value,
	input  logic [lic_pkg::SAMPLE_BITS-1:0] current_sample,
	input  logic [lic_pkg::SAMPLE_BITS-1:0] voltage_sample,
	input  lic_pkg::cfg_t                   cfg,
	input  logic                            cfg_busy,
	input  logic                            q_full,
	output logic                            q_push,
	output lic_pkg::op_t                    q_data
);

	localparam int ADDR_W = lic_pkg::ADDR_W;
	localparam int LEN_W  = lic_pkg::LEN_W;
	localparam int CNT_W  = lic_pkg::CNT_W;

	logic [ADDR_W-1:0] pos_q;
	logic [CNT_W-1:0]  cd_q;
	logic              run_q;

	logic             accept;
	logic             is_load;
	logic             is_start;
	logic             is_sample;
	logic [LEN_W-1:0] pos_ext;
	logic [LEN_W-1:0] cpos;
	logic [LEN_W:0]   cos_sum;
	logic [LEN_W-1:0] cos_idx;
	logic [CNT_W-1:0] meas_ext;
	logic [LEN_W-1:0] pos_inc;
	logic             wrap;
	logic [CNT_W-1:0] cd_dec;
	logic             clear;
	logic             acc;
	logic             emit;

	assign full   = q_full | cfg_busy;
	assign accept = push & ~full;

	always_comb begin
		is_load   = 1'b0;
		is_start  = 1'b0;
		is_sample = 1'b0;
		case (lic_pkg::opcode_t'(opcode))
			lic_pkg::OP_LOAD:   is_load = 1'b1;
			lic_pkg::OP_START:  is_start = 1'b1;
			lic_pkg::OP_SAMPLE: is_sample = 1'b1;
			default: ;
		endcase
	end

	always_comb begin
		pos_ext  = {1'b0, pos_q};
		cpos     = (pos_ext < cfg.len) ? pos_ext : '0;
		cos_sum  = {1'b0, cpos} + {2'b0, cfg.cos_off};
		// cos_off is already reduced below len, so one subtract wraps it
		if (cos_sum >= {1'b0, cfg.len}) cos_idx = LEN_W'(cos_sum - {1'b0, cfg.len});
		else cos_idx = LEN_W'(cos_sum);
		meas_ext = {1'b0, cfg.meas};
		clear    = (pos_q == '0) && (cd_q == meas_ext);
		acc      = (cd_q <= meas_ext);
		pos_inc  = pos_ext + LEN_W'(1);
		wrap     = (pos_inc >= cfg.len);
		cd_dec   = cd_q - CNT_W'(1);
		emit     = wrap && (cd_dec == '0);
	end

	assign q_push = accept & (is_load | (is_sample & run_q));

	always_comb begin
		q_data.is_load = is_load;
		q_data.wr_ok   = (32'(table_address) < TABLE_DEPTH);
		q_data.addr    = table_address;
		q_data.value   = table_value;
		q_data.sin_idx = cpos[ADDR_W-1:0];
		q_data.cos_idx = cos_idx;
		q_data.cur     = current_sample;
		q_data.vol     = voltage_sample;
		q_data.clear   = clear;
		q_data.acc     = acc;
		q_data.emit    = emit;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
			cd_q  <= '0;
			run_q <= 1'b0;
		end else if (accept) begin
			if (is_start) begin
				pos_q <= '0;
				cd_q  <= {1'b0, cfg.settle} + meas_ext;
				run_q <= 1'b1;
			end else if (is_sample && run_q) begin
				if (wrap) begin
					pos_q <= '0;
					cd_q  <= cd_dec;
					if (cd_dec == '0) run_q <= 1'b0;
				end else begin
					pos_q <= pos_inc[ADDR_W-1:0];
				end
			end
		end
	end

endmodule

[rtl/lic_back.sv]
module lic_back #(
	parameter int TABLE_DEPTH = lic_pkg::TABLE_DEPTH_DEF,
	parameter int SUM_BITS    = lic_pkg::SUM_BITS_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          q_empty,
	input  lic_pkg::op_t  q_data,
	output logic          q_pop,
	input  logic          out_full,
	output logic          out_push,
	output lic_pkg::res_t out_data
);

	localparam int AW      = $clog2(TABLE_DEPTH);
	localparam int SB      = lic_pkg::SAMPLE_BITS;
	localparam int VALUE_W = lic_pkg::VALUE_W;
	localparam int OUT_W   = lic_pkg::OUT_W;
	localparam int PROD_W  = SB + VALUE_W + 1;

	logic [VALUE_W-1:0] table_mem [TABLE_DEPTH];

	logic advance;
	logic head_sample;

	logic                      v_s2;
	logic signed [VALUE_W-1:0] sin_s2;
	logic signed [VALUE_W-1:0] cos_s2;
	logic [SB-1:0]             cur_s2;
	logic [SB-1:0]             vol_s2;
	logic                      clear_s2;
	logic                      acc_s2;
	logic                      emit_s2;
	logic signed [SB:0]        cur_x;
	logic signed [SB:0]        vol_x;

	logic                     v_s3;
	logic signed [PROD_W-1:0] cur_c_s3;
	logic signed [PROD_W-1:0] cur_s_s3;
	logic signed [PROD_W-1:0] vol_c_s3;
	logic signed [PROD_W-1:0] vol_s_s3;
	logic                     clear_s3;
	logic                     acc_s3;
	logic                     emit_s3;

	logic signed [SUM_BITS-1:0] cur_re_q;
	logic signed [SUM_BITS-1:0] cur_im_q;
	logic signed [SUM_BITS-1:0] vol_re_q;
	logic signed [SUM_BITS-1:0] vol_im_q;
	logic                       emit_s4;

	// the whole pipe freezes only while a finished result cannot leave
	assign advance     = ~(emit_s4 & out_full);
	assign q_pop       = ~q_empty & advance;
	assign head_sample = q_pop & ~q_data.is_load;

	always_ff @(posedge clk) begin
		if (q_pop && q_data.is_load && q_data.wr_ok) table_mem[AW'(q_data.addr)] <= q_data.value;
	end

	always_ff @(posedge clk) begin
		if (head_sample) begin
			sin_s2 <= table_mem[AW'(q_data.sin_idx)];
			cos_s2 <= table_mem[AW'(q_data.cos_idx)];
		end
	end

	assign cur_x = {1'b0, cur_s2};
	assign vol_x = {1'b0, vol_s2};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2    <= 1'b0;
			v_s3    <= 1'b0;
			emit_s4 <= 1'b0;
		end else if (advance) begin
			v_s2    <= head_sample;
			v_s3    <= v_s2;
			emit_s4 <= v_s3 & emit_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			if (head_sample) begin
				cur_s2   <= q_data.cur;
				vol_s2   <= q_data.vol;
				clear_s2 <= q_data.clear;
				acc_s2   <= q_data.acc;
				emit_s2  <= q_data.emit;
			end
			cur_c_s3 <= cur_x * cos_s2;
			cur_s_s3 <= cur_x * sin_s2;
			vol_c_s3 <= vol_x * cos_s2;
			vol_s_s3 <= vol_x * sin_s2;
			clear_s3 <= clear_s2;
			acc_s3   <= acc_s2;
			emit_s3  <= emit_s2;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_re_q <= '0;
			cur_im_q <= '0;
			vol_re_q <= '0;
			vol_im_q <= '0;
		end else if (advance && v_s3 && acc_s3) begin
			cur_re_q <= (clear_s3 ? '0 : cur_re_q) + SUM_BITS'(cur_c_s3);
			cur_im_q <= (clear_s3 ? '0 : cur_im_q) - SUM_BITS'(cur_s_s3);
			vol_re_q <= (clear_s3 ? '0 : vol_re_q) + SUM_BITS'(vol_c_s3);
			vol_im_q <= (clear_s3 ? '0 : vol_im_q) - SUM_BITS'(vol_s_s3);
		end
	end

	assign out_push        = emit_s4 & ~out_full;
	assign out_data.cur_re = OUT_W'(cur_re_q);
	assign out_data.cur_im = OUT_W'(cur_im_q);
	assign out_data.vol_re = OUT_W'(vol_re_q);
	assign out_data.vol_im = OUT_W'(vol_im_q);

endmodule

[rtl/dual_channel_lockin_correlator.sv]
// Dual-channel lock-in correlator. Load items fill the sine reference table, a start item
// arms settle_buffers + measure_buffers buffers, and sample pairs of the measure buffers
// are correlated against the table at their buffer position (sine) and at that position
// plus the cosine offset, wrapped at the buffer length (cosine). One result with the four
// sums comes out after the last pair of the last buffer. Steady rate is one item per clock
// while full is low; a four-entry queue sits between the classifier and the table/MAC
// pipeline, and a two-entry queue holds results, so waiting results stall the input only
// when both fill. After reset and after every write of buffer_length or cosine_offset,
// full stays high while the cosine offset is reduced modulo the length, one bit per cycle.
// Table entries must be loaded before a measurement reads them. cfg_ready is always high.
module dual_channel_lockin_correlator #(
	parameter int TABLE_DEPTH = lic_pkg::TABLE_DEPTH_DEF,
	parameter int SUM_BITS    = lic_pkg::SUM_BITS_DEF
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   push,
	output logic                                   full,
	input  logic [1:0]                             opcode,
	input  logic [lic_pkg::ADDR_W-1:0]             table_address,
	input  logic signed [lic_pkg::VALUE_W-1:0]     table_value,
	input  logic [lic_pkg::SAMPLE_BITS-1:0]        current_sample,
	input  logic [lic_pkg::SAMPLE_BITS-1:0]        voltage_sample,
	output logic                                   empty,
	input  logic                                   pop,
	output logic signed [lic_pkg::OUT_W-1:0]       current_real,
	output logic signed [lic_pkg::OUT_W-1:0]       current_imag,
	output logic signed [lic_pkg::OUT_W-1:0]       voltage_real,
	output logic signed [lic_pkg::OUT_W-1:0]       voltage_imag,
	input  logic                                   cfg_valid,
	output logic                                   cfg_ready,
	input  logic [lic_pkg::CFG_IDX_W-1:0]          cfg_index,
	input  logic [lic_pkg::CFG_DATA_W-1:0]         cfg_data
);

	localparam int LEN_W = lic_pkg::LEN_W;
	localparam int OFF_W = lic_pkg::OFF_W;
	localparam int BUF_W = lic_pkg::BUF_W;

	logic [LEN_W-1:0] buf_len_q;
	logic [OFF_W-1:0] cos_off_q;
	logic [BUF_W-1:0] settle_q;
	logic [BUF_W-1:0] meas_q;

	logic             cfg_wr;
	logic             div_start;
	logic             div_busy;
	logic [OFF_W-1:0] off_mod;
	logic [LEN_W-1:0] eff_len;
	lic_pkg::cfg_t    cfg;

	logic          mid_push;
	lic_pkg::op_t  mid_wdata;
	logic          mid_pop;
	lic_pkg::op_t  mid_rdata;
	logic          mid_full;
	logic          mid_empty;

	logic          out_push;
	lic_pkg::res_t out_wdata;
	lic_pkg::res_t out_rdata;
	logic          out_full;

	assign cfg_ready = 1'b1;
	assign cfg_wr    = cfg_valid & cfg_ready;
	assign div_start = cfg_wr && (cfg_index == lic_pkg::REG_BUFFER_LENGTH
		|| cfg_index == lic_pkg::REG_COSINE_OFFSET);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			buf_len_q <= lic_pkg::BUFFER_LENGTH_RST;
			cos_off_q <= lic_pkg::COSINE_OFFSET_RST;
			settle_q  <= lic_pkg::SETTLE_BUFFERS_RST;
			meas_q    <= lic_pkg::MEASURE_BUFFERS_RST;
		end else if (cfg_wr) begin
			case (lic_pkg::cfg_reg_t'(cfg_index))
				lic_pkg::REG_BUFFER_LENGTH:   buf_len_q <= cfg_data;
				lic_pkg::REG_COSINE_OFFSET:   cos_off_q <= cfg_data[OFF_W-1:0];
				lic_pkg::REG_SETTLE_BUFFERS:  settle_q <= cfg_data[BUF_W-1:0];
				lic_pkg::REG_MEASURE_BUFFERS: meas_q <= cfg_data[BUF_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		if (buf_len_q == '0) eff_len = LEN_W'(1);
		else if (32'(buf_len_q) > TABLE_DEPTH) eff_len = LEN_W'(TABLE_DEPTH);
		else eff_len = buf_len_q;
	end

	always_comb begin
		cfg.len     = eff_len;
		cfg.cos_off = off_mod;
		cfg.settle  = settle_q;
		cfg.meas    = (meas_q == '0) ? BUF_W'(1) : meas_q;
	end

	lic_offset_mod u_offset_mod (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (cos_off_q),
		.divisor  (eff_len),
		.busy     (div_busy),
		.rem      (off_mod)
	);

	lic_front #(
		.TABLE_DEPTH (TABLE_DEPTH)
	) u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.push           (push),
		.full           (full),
		.opcode         (opcode),
		.table_address  (table_address),
		.table_value    (table_value),
		.current_sample (current_sample),
		.voltage_sample (voltage_sample),
		.cfg            (cfg),
		.cfg_busy       (div_busy),
		.q_full         (mid_full),
		.q_push         (mid_push),
		.q_data         (mid_wdata)
	);

	lic_fifo #(
		.T     (lic_pkg::op_t),
		.DEPTH (lic_pkg::MID_DEPTH)
	) u_mid_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (mid_push),
		.wdata  (mid_wdata),
		.pop    (mid_pop),
		.rdata  (mid_rdata),
		.full   (mid_full),
		.empty  (mid_empty)
	);

	lic_back #(
		.TABLE_DEPTH (TABLE_DEPTH),
		.SUM_BITS    (SUM_BITS)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_empty  (mid_empty),
		.q_data   (mid_rdata),
		.q_pop    (mid_pop),
		.out_full (out_full),
		.out_push (out_push),
		.out_data (out_wdata)
	);

	lic_fifo #(
		.T     (lic_pkg::res_t),
		.DEPTH (lic_pkg::OUT_DEPTH)
	) u_out_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (out_push),
		.wdata  (out_wdata),
		.pop    (pop),
		.rdata  (out_rdata),
		.full   (out_full),
		.empty  (empty)
	);

	assign current_real = out_rdata.cur_re;
	assign current_imag = out_rdata.cur_im;
	assign voltage_real = out_rdata.vol_re;
	assign voltage_imag = out_rdata.vol_im;

endmodule

[rtl/lic_checker.sv]
module lic_checker (
	input logic                               clk,
	input logic                               arst_n,
	input logic                               full,
	input logic                               empty,
	input logic                               pop,
	input logic [lic_pkg::OUT_W-1:0]          current_real,
	input logic [lic_pkg::OUT_W-1:0]          voltage_imag,
	input logic                               cfg_valid,
	input logic                               cfg_ready,
	input logic [lic_pkg::CFG_IDX_W-1:0]      cfg_index
);

	// a new length restarts the offset reduction, so input is held off for a while
	assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid && cfg_ready && cfg_index == lic_pkg::REG_BUFFER_LENGTH |=> full ##1 full)
		else $error("input open right after a length write");

	assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid && cfg_ready && cfg_index == lic_pkg::REG_COSINE_OFFSET |=> full ##1 full)
		else $error("input open right after an offset write");

	assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !pop |=> !empty)
		else $error("result dropped without a transfer");

	assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !pop |=> $stable(current_real) && $stable(voltage_imag))
		else $error("waiting result changed");

endmodule

bind dual_channel_lockin_correlator lic_checker u_lic_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.full         (full),
	.empty        (empty),
	.pop          (pop),
	.current_real (current_real),
	.voltage_imag (voltage_imag),
	.cfg_valid    (cfg_valid),
	.cfg_ready    (cfg_ready),
	.cfg_index    (cfg_index)
);

[verif/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;

	localparam int CYCLE_LIMIT = 600000;
	localparam int HOLD_CYCLES = 300;
	localparam int TAB_DEPTH   = 1024;
	localparam int IDLE_WAIT   = 20;
	localparam int ITEM_TARGET = 1100;
	localparam logic [1:0] OP_UNUSED = 2'd3;

	localparam lic_pkg::res_t ZERO_RES = '0;
	// one full-scale current pair at position 0: sine 32767, cosine -32768
	localparam lic_pkg::res_t TONE_RES = '{-48'sd134184960, -48'sd134180865, 48'd0, 48'd0};

	typedef struct {
		logic [1:0]    op;
		logic [9:0]    addr;
		logic [15:0]   val;
		logic [11:0]   cur;
		logic [11:0]   vol;
		bit            typed;
		lic_pkg::res_t want;
	} stim_row_t;

	logic clk = 1'b0;
	logic arst_n;
	logic push;
	logic full;
	logic [1:0] opcode;
	logic [lic_pkg::ADDR_W-1:0] table_address;
	logic signed [lic_pkg::VALUE_W-1:0] table_value;
	logic [lic_pkg::SAMPLE_BITS-1:0] current_sample;
	logic [lic_pkg::SAMPLE_BITS-1:0] voltage_sample;
	logic empty;
	logic pop;
	logic signed [lic_pkg::OUT_W-1:0] current_real;
	logic signed [lic_pkg::OUT_W-1:0] current_imag;
	logic signed [lic_pkg::OUT_W-1:0] voltage_real;
	logic signed [lic_pkg::OUT_W-1:0] voltage_imag;
	logic cfg_valid;
	logic cfg_ready;
	logic [lic_pkg::CFG_IDX_W-1:0] cfg_index;
	logic [lic_pkg::CFG_DATA_W-1:0] cfg_data;

	// correlator state as predicted
	logic [15:0] sine_table [TAB_DEPTH];
	bit tab_loaded [TAB_DEPTH];
	int unsigned pair_pos;
	logic [7:0] bufs_left;
	bit meas_active;
	logic [47:0] sum_cur_re, sum_cur_im, sum_vol_re, sum_vol_im;
	logic [10:0] len_reg;
	logic [9:0] cos_off_reg;
	logic [6:0] settle_reg, meas_reg;

	lic_pkg::res_t expected_sums [$];
	int failures = 0;
	int items_done = 0;
	bit tx_busy = 1'b1;
	bit rx_busy = 1'b1;
	bit hold_req = 1'b0;

	stim_row_t directed_rows [25] = '{
		'{lic_pkg::OP_SAMPLE, 10'd0,   16'h0000, 12'hFFF, 12'hFFF, 1'b0, ZERO_RES}, // idle
		'{OP_UNUSED,          10'h3FF, 16'hFFFF, 12'hFFF, 12'hFFF, 1'b0, ZERO_RES},
		'{lic_pkg::OP_LOAD,   10'd0,   16'h7FFF, 12'd0,   12'd0,   1'b0, ZERO_RES},
		'{lic_pkg::OP_LOAD,   10'd1,   16'h8000, 12'd0,   12'd0,   1'b0, ZERO_RES},
		'{lic_pkg::OP_LOAD,   10'd2,   16'h0000, 12'd0,   12'd0,   1'b0, ZERO_RES},
		'{lic_pkg::OP_LOAD,   10'd3,   16'h0001, 12'd0,   12'd0,   1'b0, ZERO_RES},
		'{lic_pkg::OP_LOAD,   10'h3FF, 16'h5A5A, 12'd0,   12'd0,   1'b0, ZERO_RES},
		'{lic_pkg::OP_START,  10'd0,   16'h0000, 12'd0,   12'd0,   1'b0, ZERO_RES},
		'{lic_pkg::OP_SAMPLE, 10'd0,   16'h0000, 12'd0,   12'd0,   1'b0, ZERO_RES},
		'{lic_pkg::OP_SAMPLE, 10'd0,   16'h0000, 12'd0,   12'd0,   1'b0, ZERO_RES},
		'{lic_pkg::OP_SAMPLE, 10'd0,   16'h0000, 12'd0,   12'd0,   1'b0, ZERO_RES},
		'{lic_pkg::OP_SAMPLE, 10'd0,   16'h0000, 12'd0,   12'd0,   1'b1, ZERO_RES},
		'{lic_pkg::OP_START,  10'd0,   16'h0000, 12'd0,   12'd0,   1'b0, ZERO_RES},
		'{lic_pkg::OP_SAMPLE, 10'd0,   16'h0000, 12'hFFF, 12'd0,   1'b0, ZERO_RES},
		'{lic_pkg::OP_SAMPLE, 10'd0,   16'h0000, 12'd0,   12'd0,   1'b0, ZERO_RES},
		'{lic_pkg::OP_SAMPLE, 10'd0,   16'h0000, 12'd0,   12'd0,   1'b0, ZERO_RES},
		'{lic_pkg::OP_SAMPLE, 10'd0,   16'h0000, 12'd0,   12'd0,   1'b1, TONE_RES},
		'{lic_pkg::OP_START,  10'd0,   16'h0000, 12'd0,   12'd0,   1'b0, ZERO_RES},
		'{lic_pkg::OP_SAMPLE, 10'd0,   16'h0000, 12'd0,   12'hFFF, 1'b0, ZERO_RES},
		'{lic_pkg::OP_START,  10'd0,   16'h0000, 12'd0,   12'd0,   1'b0, ZERO_RES}, // restart
		'{lic_pkg::OP_SAMPLE, 10'd0,   16'h0000, 12'd1234, 12'd2345, 1'b0, ZERO_RES},
		'{lic_pkg::OP_LOAD,   10'd2,   16'hCFC7, 12'd0,   12'd0,   1'b0, ZERO_RES}, // mid-run
		'{lic_pkg::OP_SAMPLE, 10'd0,   16'h0000, 12'd3000, 12'd7,   1'b0, ZERO_RES},
		'{lic_pkg::OP_SAMPLE, 10'd0,   16'h0000, 12'd5,    12'd4000, 1'b0, ZERO_RES},
		'{lic_pkg::OP_SAMPLE, 10'd0,   16'h0000, 12'd2048, 12'd2047, 1'b0, ZERO_RES}
	};

	dual_channel_lockin_correlator i_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.push           (push),
		.full           (full),
		.opcode         (opcode),
		.table_address  (table_address),
		.table_value    (table_value),
		.current_sample (current_sample),
		.voltage_sample (voltage_sample),
		.empty          (empty),
		.pop            (pop),
		.current_real   (current_real),
		.current_imag   (current_imag),
		.voltage_real   (voltage_real),
		.voltage_imag   (voltage_imag),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data)
	);

	always #4 clk = ~clk;

	function automatic int unsigned eff_len();
		if (len_reg == 0) return 1;
		if (len_reg > TAB_DEPTH) return TAB_DEPTH;
		return 32'(len_reg);
	endfunction

	function automatic int unsigned eff_meas();
		return (meas_reg == 0) ? 1 : 32'(meas_reg);
	endfunction

	// advances the predicted state by one item; returns 1 when the sums come out
	function automatic bit correlate_item(input logic [1:0] op, input logic [9:0] addr,
		input logic [15:0] val, input logic [11:0] cur, input logic [11:0] vol,
		output lic_pkg::res_t sums);
		int unsigned len, meas, spos, cidx;
		logic signed [47:0] cur_x, vol_x, sin_x, cos_x;
		sums = '0;
		case (op)
			lic_pkg::OP_LOAD: begin
				sine_table[addr] = val;
				tab_loaded[addr] = 1'b1;
				return 1'b0;
			end
			lic_pkg::OP_START: begin
				pair_pos = 0;
				bufs_left = 8'(settle_reg + eff_meas());
				meas_active = 1'b1;
				return 1'b0;
			end
			lic_pkg::OP_SAMPLE: ;
			default: return 1'b0;
		endcase
		if (!meas_active)
			return 1'b0;
		len = eff_len();
		meas = eff_meas();
		if (pair_pos == 0 && bufs_left == meas) begin
			sum_cur_re = '0;
			sum_cur_im = '0;
			sum_vol_re = '0;
			sum_vol_im = '0;
		end
		if (bufs_left <= meas) begin
			spos = (pair_pos < len) ? pair_pos : 0;
			cidx = (spos + cos_off_reg) % len;
			sin_x = {{32{sine_table[spos][15]}}, sine_table[spos]};
			cos_x = {{32{sine_table[cidx][15]}}, sine_table[cidx]};
			cur_x = {36'd0, cur};
			vol_x = {36'd0, vol};
			sum_cur_re = sum_cur_re + cur_x * cos_x;
			sum_cur_im = sum_cur_im - cur_x * sin_x;
			sum_vol_re = sum_vol_re + vol_x * cos_x;
			sum_vol_im = sum_vol_im - vol_x * sin_x;
		end
		if (pair_pos + 1 >= len) begin
			pair_pos = 0;
			bufs_left = bufs_left - 8'd1;
			if (bufs_left == 0) begin
				meas_active = 1'b0;
				sums.cur_re = sum_cur_re;
				sums.cur_im = sum_cur_im;
				sums.vol_re = sum_vol_re;
				sums.vol_im = sum_vol_im;
				return 1'b1;
			end
		end else begin
			pair_pos = pair_pos + 1;
		end
		return 1'b0;
	endfunction

	task automatic send_item(input logic [1:0] op, input logic [9:0] addr,
		input logic [15:0] val, input logic [11:0] cur, input logic [11:0] vol,
		input bit typed = 1'b0, input lic_pkg::res_t want = '0);
		int gap;
		lic_pkg::res_t sums;
		gap = tx_busy ? $urandom_range(0, 19) : 0;
		if (gap > 0) begin
			push <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		push <= 1'b1;
		opcode <= op;
		table_address <= addr;
		table_value <= val;
		current_sample <= cur;
		voltage_sample <= vol;
		@(posedge clk);
		while (full) @(posedge clk);
		// transfer done at this edge
		items_done++;
		if (correlate_item(op, addr, val, cur, vol, sums))
			expected_sums.push_back(typed ? want : sums);
	endtask

	task automatic send_sample();
		send_item(lic_pkg::OP_SAMPLE, 10'($urandom), 16'($urandom), 12'($urandom),
			12'($urandom));
	endtask

	task automatic send_start();
		send_item(lic_pkg::OP_START, 10'($urandom), 16'($urandom), 12'($urandom),
			12'($urandom));
	endtask

	task automatic send_load(input logic [9:0] addr);
		send_item(lic_pkg::OP_LOAD, addr, 16'($urandom), 12'($urandom), 12'($urandom));
	endtask

	task automatic send_unused();
		send_item(OP_UNUSED, 10'($urandom), 16'($urandom), 12'($urandom), 12'($urandom));
	endtask

	task automatic write_reg(input lic_pkg::cfg_reg_t idx, input logic [10:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		case (idx)
			lic_pkg::REG_BUFFER_LENGTH:   len_reg = data;
			lic_pkg::REG_COSINE_OFFSET:   cos_off_reg = data[9:0];
			lic_pkg::REG_SETTLE_BUFFERS:  settle_reg = data[6:0];
			lic_pkg::REG_MEASURE_BUFFERS: meas_reg = data[6:0];
			default: ;
		endcase
	endtask

	task automatic program_regs(input logic [10:0] len, input logic [9:0] off,
		input logic [6:0] settle, input logic [6:0] meas);
		write_reg(lic_pkg::REG_BUFFER_LENGTH, len);
		write_reg(lic_pkg::REG_COSINE_OFFSET, 11'(off));
		write_reg(lic_pkg::REG_SETTLE_BUFFERS, 11'(settle));
		write_reg(lic_pkg::REG_MEASURE_BUFFERS, 11'(meas));
		cfg_valid <= 1'b0;
	endtask

	task automatic wait_idle();
		push <= 1'b0;
		while (expected_sums.size() != 0) @(posedge clk);
		repeat (IDLE_WAIT) @(posedge clk);
	endtask

	// every entry a measurement can read must be loaded before the start
	task automatic ensure_table(input int unsigned len);
		for (int i = 0; i < len; i++)
			if (!tab_loaded[i])
				send_load(10'(i));
	endtask

	task automatic measure_once();
		int step;
		int restart_at;
		int r;
		step = 0;
		restart_at = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 20) : -1;
		if ($urandom_range(0, 4) == 0)
			send_sample();
		if ($urandom_range(0, 4) == 0)
			send_unused();
		send_start();
		while (meas_active) begin
			r = $urandom_range(0, 99);
			if (step == restart_at)
				send_start();
			else if (r < 4)
				send_unused();
			else if (r < 9)
				send_load(10'($urandom));
			else
				send_sample();
			step++;
		end
	endtask

	task automatic run_phase(input logic [10:0] len, input logic [9:0] off,
		input logic [6:0] settle, input logic [6:0] meas, input int runs);
		wait_idle();
		tx_busy = ($urandom_range(0, 3) != 0);
		rx_busy = ($urandom_range(0, 3) != 0);
		program_regs(len, off, settle, meas);
		ensure_table(eff_len());
		repeat (runs) measure_once();
	endtask

	function automatic void check_field(input string what, input logic [47:0] want,
		input logic [47:0] got);
		if (want !== got) begin
			failures++;
			if (failures <= 10)
				$display("mismatch %s: expected %0d, got %0d", what, $signed(want),
					$signed(got));
		end
	endfunction

	initial begin : result_sink
		lic_pkg::res_t want;
		int gap;
		wait (arst_n === 1'b1);
		forever begin
			if (hold_req) begin
				pop <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_req = 1'b0;
			end
			gap = rx_busy ? $urandom_range(0, 19) : 0;
			if (gap > 0) begin
				pop <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			pop <= 1'b1;
			@(posedge clk);
			while (empty) @(posedge clk);
			if (expected_sums.size() == 0) begin
				failures++;
				if (failures <= 10)
					$display("unexpected result: %0d %0d %0d %0d", current_real,
						current_imag, voltage_real, voltage_imag);
			end else begin
				want = expected_sums.pop_front();
				check_field("current_real", want.cur_re, current_real);
				check_field("current_imag", want.cur_im, current_imag);
				check_field("voltage_real", want.vol_re, voltage_real);
				check_field("voltage_imag", want.vol_im, voltage_imag);
			end
		end
	end

	initial begin : watchdog
		int unsigned cycle_count;
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("Verification failed");
		$finish;
	end

	initial begin : stimulus
		int pick;
		logic [10:0] rl;
		logic [9:0] ro;
		logic [6:0] rs, rm;

		foreach (sine_table[i]) begin
			sine_table[i] = '0;
			tab_loaded[i] = 1'b0;
		end
		pair_pos = 0;
		bufs_left = '0;
		meas_active = 1'b0;
		sum_cur_re = '0;
		sum_cur_im = '0;
		sum_vol_re = '0;
		sum_vol_im = '0;
		len_reg = lic_pkg::BUFFER_LENGTH_RST;
		cos_off_reg = lic_pkg::COSINE_OFFSET_RST;
		settle_reg = lic_pkg::SETTLE_BUFFERS_RST;
		meas_reg = lic_pkg::MEASURE_BUFFERS_RST;

		arst_n <= 1'b0;
		push <= 1'b0;
		pop <= 1'b0;
		opcode <= lic_pkg::OP_LOAD;
		table_address <= '0;
		table_value <= '0;
		current_sample <= '0;
		voltage_sample <= '0;
		cfg_valid <= 1'b0;
		cfg_index <= lic_pkg::REG_BUFFER_LENGTH;
		cfg_data <= '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		program_regs(11'd4, 10'd1, 7'd0, 7'd1);
		foreach (directed_rows[i])
			send_item(directed_rows[i].op, directed_rows[i].addr, directed_rows[i].val,
				directed_rows[i].cur, directed_rows[i].vol, directed_rows[i].typed,
				directed_rows[i].want);

		// back-to-back one-pair measurements while the sink holds off
		run_phase(11'd1, 10'd5, 7'd0, 7'd1, 0);
		tx_busy = 1'b0;
		hold_req = 1'b1;
		repeat (40) begin
			send_start();
			send_sample();
		end

		// length 0 with the longest countdown
		run_phase(11'd0, 10'd0, 7'd127, 7'd127, 1);

		while (items_done < ITEM_TARGET) begin
			pick = $urandom_range(0, 9);
			ro = 10'($urandom_range(0, 1023));
			rs = 7'($urandom_range(0, 3));
			rm = 7'($urandom_range(0, 4));
			if (pick == 0) begin
				rl = 11'($urandom_range(0, 3));
				if ($urandom_range(0, 1) == 0)
					rs = 7'($urandom_range(0, 127));
			end else if (pick == 9) begin
				rl = 11'($urandom_range(33, 200));
				rs = 7'd0;
				rm = 7'($urandom_range(0, 2));
			end else begin
				rl = 11'($urandom_range(4, 32));
			end
			run_phase(rl, ro, rs, rm, $urandom_range(1, 3));
		end

		wait_idle();
		if (failures == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule

[dual_channel_lockin_correlator.f]
rtl/lic_pkg.sv
rtl/lic_fifo.sv
rtl/lic_offset_mod.sv
rtl/lic_front.sv
rtl/lic_back.sv
rtl/dual_channel_lockin_correlator.sv
rtl/lic_checker.sv
verif/tb_top.sv
